### hw/rtl/ima_adpcm_nibble_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// IMA ADPCM nibble decoder assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IMA_ADPCM_NIBBLE_DECODER_UNIT_ASSERT_SVH
`define IMA_ADPCM_NIBBLE_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// a holds on every edge out of reset
`define IAD_ASSERT(label, a, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a)) else $error(msg);

// a implies b on the same edge
`define IAD_ASSERT_IMPL(label, a, b, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) else $error(msg);

// a implies b on the next edge
`define IAD_ASSERT_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error(msg);

`else

`define IAD_ASSERT(label, a, msg)
`define IAD_ASSERT_IMPL(label, a, b, msg)
`define IAD_ASSERT_NEXT(label, a, b, msg)

`endif

`endif

### hw/rtl/iad_pkg.sv
// ----------------------------------------------------------------------------
// IMA ADPCM nibble decoder package
// Types, limits and the step / index tables shared by the decoder files.
// ----------------------------------------------------------------------------
package iad_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned StepW   = 15;

  localparam logic [IndexW-1:0] MaxIndex = 7'd88;

  // predictor plus or minus difference, wide enough to clip afterwards
  localparam int unsigned SumW = SampleW + 2;
  localparam logic signed [SumW-1:0] PosLimit = 18'sd32767;
  localparam logic signed [SumW-1:0] NegLimit = -18'sd32767;

  typedef enum logic {
    ActHeader = 1'b0,
    ActData   = 1'b1
  } action_e;

  typedef struct packed {
    action_e                    action;
    logic signed [SampleW-1:0]  header_sample;
    logic [IndexW-1:0]          header_index;
    logic [7:0]                 data_byte;
    logic                       final_byte;
  } item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] pred;
    logic [IndexW-1:0]         idx;
  } dec_state_t;

  function automatic logic [StepW-1:0] step_size(input logic [IndexW-1:0] idx);
    logic [StepW-1:0] s;
    case (idx)
      7'd0: s = 15'd7;         7'd1: s = 15'd8;         7'd2: s = 15'd9;
      7'd3: s = 15'd10;        7'd4: s = 15'd11;        7'd5: s = 15'd12;
      7'd6: s = 15'd13;        7'd7: s = 15'd14;        7'd8: s = 15'd16;
      7'd9: s = 15'd17;        7'd10: s = 15'd19;       7'd11: s = 15'd21;
      7'd12: s = 15'd23;       7'd13: s = 15'd25;       7'd14: s = 15'd28;
      7'd15: s = 15'd31;       7'd16: s = 15'd34;       7'd17: s = 15'd37;
      7'd18: s = 15'd41;       7'd19: s = 15'd45;       7'd20: s = 15'd50;
      7'd21: s = 15'd55;       7'd22: s = 15'd60;       7'd23: s = 15'd66;
      7'd24: s = 15'd73;       7'd25: s = 15'd80;       7'd26: s = 15'd88;
      7'd27: s = 15'd97;       7'd28: s = 15'd107;      7'd29: s = 15'd118;
      7'd30: s = 15'd130;      7'd31: s = 15'd143;      7'd32: s = 15'd157;
      7'd33: s = 15'd173;      7'd34: s = 15'd190;      7'd35: s = 15'd209;
      7'd36: s = 15'd230;      7'd37: s = 15'd253;      7'd38: s = 15'd279;
      7'd39: s = 15'd307;      7'd40: s = 15'd337;      7'd41: s = 15'd371;
      7'd42: s = 15'd408;      7'd43: s = 15'd449;      7'd44: s = 15'd494;
      7'd45: s = 15'd544;      7'd46: s = 15'd598;      7'd47: s = 15'd658;
      7'd48: s = 15'd724;      7'd49: s = 15'd796;      7'd50: s = 15'd876;
      7'd51: s = 15'd963;      7'd52: s = 15'd1060;     7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;     7'd55: s = 15'd1411;     7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;     7'd58: s = 15'd1878;     7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;     7'd61: s = 15'd2499;     7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;     7'd64: s = 15'd3327;     7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;     7'd67: s = 15'd4428;     7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;     7'd70: s = 15'd5894;     7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;     7'd73: s = 15'd7845;     7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;     7'd76: s = 15'd10442;    7'd77: s = 15'd11487;
      7'd78: s = 15'd12635;    7'd79: s = 15'd13899;    7'd80: s = 15'd15289;
      7'd81: s = 15'd16818;    7'd82: s = 15'd18500;    7'd83: s = 15'd20350;
      7'd84: s = 15'd22385;    7'd85: s = 15'd24623;    7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;  // index 88; higher indexes never reach the table
    endcase
    return s;
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    case (mag)
      3'd4: a = 5'sd2;
      3'd5: a = 5'sd4;
      3'd6: a = 5'sd6;
      3'd7: a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/iad_in_if.sv
// ----------------------------------------------------------------------------
// IMA ADPCM input channel
// Valid/ready channel carrying one header or data item.
// ----------------------------------------------------------------------------
interface iad_in_if;
  logic                                 valid;
  logic                                 ready;
  iad_pkg::action_e                     action;
  logic signed [iad_pkg::SampleW-1:0]   header_sample;
  logic [iad_pkg::IndexW-1:0]           header_index;
  logic [7:0]                           data_byte;
  logic                                 final_byte;

  modport source (
    output valid, action, header_sample, header_index, data_byte, final_byte,
    input  ready
  );
  modport sink (
    input  valid, action, header_sample, header_index, data_byte, final_byte,
    output ready
  );
endinterface

### hw/rtl/iad_out_if.sv
// ----------------------------------------------------------------------------
// IMA ADPCM output channel
// Valid/ready channel carrying one decoded PCM16 sample.
// ----------------------------------------------------------------------------
interface iad_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iad_pkg::SampleW-1:0]   sample;
  logic                                 last;
  logic                                 sample_end;

  modport source (
    output valid, sample, last, sample_end,
    input  ready
  );
  modport sink (
    input  valid, sample, last, sample_end,
    output ready
  );
endinterface

### hw/rtl/iad_decode.sv
// ----------------------------------------------------------------------------
// IMA ADPCM code step
// Applies one 4-bit code to predictor and step index, with clipping.
// ----------------------------------------------------------------------------
module iad_decode (
  input  iad_pkg::dec_state_t cur_i,
  input  logic [3:0]          code_i,
  output iad_pkg::dec_state_t nxt_o
);

  logic [iad_pkg::StepW-1:0]          step;
  logic [iad_pkg::StepW+1:0]          diff;
  logic signed [iad_pkg::SumW-1:0]    pred_ext;
  logic signed [iad_pkg::SumW-1:0]    diff_ext;
  logic signed [iad_pkg::SumW-1:0]    sum;
  logic signed [4:0]                  adj;
  logic signed [iad_pkg::IndexW+1:0]  idx_sum;

  always_comb begin
    step = iad_pkg::step_size(cur_i.idx);

    // truncated terms, each shifted separately
    diff = {2'b00, step >> 3};
    if (code_i[0]) diff = diff + {2'b00, step >> 2};
    if (code_i[1]) diff = diff + {2'b00, step >> 1};
    if (code_i[2]) diff = diff + {2'b00, step};

    pred_ext = {{(iad_pkg::SumW-iad_pkg::SampleW){cur_i.pred[iad_pkg::SampleW-1]}},
                cur_i.pred};
    diff_ext = $signed({1'b0, diff});

    if (!code_i[3]) begin
      sum = pred_ext + diff_ext;
      if (sum > iad_pkg::PosLimit) sum = iad_pkg::PosLimit;
    end else begin
      sum = pred_ext - diff_ext;
      if (sum < iad_pkg::NegLimit) sum = iad_pkg::NegLimit;
    end
    nxt_o.pred = sum[iad_pkg::SampleW-1:0];

    adj     = iad_pkg::index_adjust(code_i[2:0]);
    idx_sum = $signed({2'b00, cur_i.idx}) + {{(iad_pkg::IndexW-3){adj[4]}}, adj};
    if (idx_sum < 0) begin
      nxt_o.idx = '0;
    end else if (idx_sum > $signed({2'b00, iad_pkg::MaxIndex})) begin
      nxt_o.idx = iad_pkg::MaxIndex;
    end else begin
      nxt_o.idx = idx_sum[iad_pkg::IndexW-1:0];
    end
  end

endmodule

### hw/rtl/ima_adpcm_nibble_decoder_unit.sv
// ----------------------------------------------------------------------------
// IMA ADPCM nibble decoder
// Header items load predictor and step index and emit one sample; data items yield two.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                            | results
//  in_i    | in  | action, header_sample, header_index, data_byte,    | -
//          |     | final_byte                                         |
//  out_o   | out | sample, last, sample_end                           | 1 or 2/item
//
//  A data item goes one nibble per cycle while the output register is free, through
//  the single code-step unit, the second nibble using the first one's state.
//  The next item is taken in the cycle its predecessor issues its last result.
//  Output register stalls hold the item register; no results are dropped.
//  Reset clears predictor, step index and all valid flags.
module ima_adpcm_nibble_decoder_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  iad_in_if.sink          in_i,
  iad_out_if.source       out_o
);

  `include "ima_adpcm_nibble_decoder_unit_assert.svh"

  iad_pkg::item_t       item_q, item_d;
  logic                 item_valid_q, item_valid_d;
  logic                 phase_q, phase_d;
  iad_pkg::dec_state_t  state_q, state_d;
  iad_pkg::dec_state_t  dec_nxt;

  logic signed [iad_pkg::SampleW-1:0] out_sample_q, out_sample_d;
  logic                 out_last_q, out_last_d;
  logic                 out_end_q, out_end_d;
  logic                 out_valid_q, out_valid_d;

  logic                 out_free;
  logic                 fire;
  logic                 done;
  logic                 in_take;
  logic [3:0]           code;
  logic [iad_pkg::IndexW-1:0] hdr_idx;

  assign out_free = !out_valid_q || out_o.ready;
  assign fire     = item_valid_q && out_free;
  assign done     = fire && ((item_q.action == iad_pkg::ActHeader) || phase_q);
  assign in_i.ready = !item_valid_q || done;
  assign in_take  = in_i.valid && in_i.ready;

  assign code    = phase_q ? item_q.data_byte[7:4] : item_q.data_byte[3:0];
  assign hdr_idx = (item_q.header_index > iad_pkg::MaxIndex) ? iad_pkg::MaxIndex
                                                             : item_q.header_index;

  iad_decode u_decode (
    .cur_i  (state_q),
    .code_i (code),
    .nxt_o  (dec_nxt)
  );

  always_comb begin
    item_d       = item_q;
    item_valid_d = item_valid_q;
    phase_d      = phase_q;
    state_d      = state_q;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    out_end_d    = out_end_q;
    out_valid_d  = out_valid_q && !out_o.ready;

    if (fire) begin
      out_valid_d = 1'b1;
      if (item_q.action == iad_pkg::ActHeader) begin
        state_d.pred = item_q.header_sample;
        state_d.idx  = hdr_idx;
        out_sample_d = item_q.header_sample;
        out_last_d   = 1'b1;
        out_end_d    = 1'b0;
        phase_d      = 1'b0;
      end else begin
        state_d      = dec_nxt;
        out_sample_d = dec_nxt.pred;
        out_last_d   = phase_q;
        out_end_d    = phase_q && item_q.final_byte;
        phase_d      = !phase_q;
      end
    end

    if (done) item_valid_d = 1'b0;

    if (in_take) begin
      item_valid_d          = 1'b1;
      item_d.action         = in_i.action;
      item_d.header_sample  = in_i.header_sample;
      item_d.header_index   = in_i.header_index;
      item_d.data_byte      = in_i.data_byte;
      item_d.final_byte     = in_i.final_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      phase_q      <= 1'b0;
      state_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      phase_q      <= phase_d;
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
    out_end_q    <= out_end_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample     = out_sample_q;
  assign out_o.last       = out_last_q;
  assign out_o.sample_end = out_end_q;

  // second nibble pending only for a held data item
  `IAD_ASSERT_IMPL(a_phase_data, phase_q, item_valid_q && (item_q.action == iad_pkg::ActData), "phase set without a data item")
  // an item replaces the held one only when that one finishes
  `IAD_ASSERT_IMPL(a_take_on_done, in_take && item_valid_q, done, "held item overwritten")
  `IAD_ASSERT_IMPL(a_end_is_last, out_valid_q && out_end_q, out_last_q, "sample_end without last")
  `IAD_ASSERT(a_index_range, state_q.idx <= iad_pkg::MaxIndex, "step index above table")
  // first nibble always followed by the second in the next issue
  `IAD_ASSERT_NEXT(a_first_nibble, fire && (item_q.action == iad_pkg::ActData) && !phase_q, phase_q && item_valid_q, "second nibble lost")

endmodule
